// ----- rtl/pgr_pkg.sv -----
// shared types, constants and helpers of the polyline grid rasterizer
package pgr_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CRD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int DIM_W   = 7;
    localparam int CFG_I_W = 1;
    localparam int CRD_IN_W = 16;
    localparam int CNT_W    = 16;

    typedef enum logic [CFG_I_W-1:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        FN_START  = 2'd0,
        FN_VERTEX = 2'd1,
        FN_READ   = 2'd2,
        FN_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RAISED  = 2'd1,
        ST_IGNORED = 2'd2,
        ST_REFUSED = 2'd3
    } status_t;

    typedef struct packed {
        logic xinc;
        logic xdec;
        logic yinc;
        logic ydec;
    } step_t;

    // register value to dimension in use: zero acts as one, clamp to the maximum
    function automatic logic [CRD_IN_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                   input int maxv);
        logic [CRD_IN_W-1:0] r;
        if (v == '0)
            r = CRD_IN_W'(1);
        else if (CRD_IN_W'(v) > CRD_IN_W'(maxv))
            r = CRD_IN_W'(maxv);
        else
            r = CRD_IN_W'(v);
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] y,
                                                    input logic [COL_W-1:0] x);
        return ADDR_W'(y) * ADDR_W'(MAX_COLS) + ADDR_W'(x);
    endfunction

endpackage

// ----- rtl/pgr_in_if.sv -----
// input channel: one item per beat
interface pgr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] x;
    logic [15:0] y;

    modport source (output valid, output func, output x, output y, input ready);
    modport sink   (input valid, input func, input x, input y, output ready);
endinterface

// ----- rtl/pgr_out_if.sv -----
// result channel: one result per beat
interface pgr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] err_line;
    logic [15:0] err_vertex;
    logic        cell_res;

    modport source (output valid, output status, output err_line, output err_vertex,
                    output cell_res, input ready);
    modport sink   (input valid, input status, input err_line, input err_vertex,
                    input cell_res, output ready);
endinterface

// ----- rtl/pgr_ram.sv -----
// generic simple dual-port ram with registered read
module pgr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/polyline_grid_rasterizer_unit.sv -----
// top level of the polyline grid rasterizer: sequencer, walker and bitmap
//
//  channel  | dir | beat contents                                 | handshake
//  ---------+-----+-----------------------------------------------+-----------
//  item     | in  | func, x, y                                    | valid/ready
//  result   | out | status, err_line, err_vertex, cell_res        | valid/ready
//  cfg      | in  | cfg_wen, cfg_index, cfg_data (grid cols/rows) | write only
//
// start, vertex that fails or is ignored, refused read, unused func: the result goes
//   through S_EXEC and S_DONE into the result register; a cell read adds S_READ
// drawing vertex: S_EXEC, S_WALK for every cell of the segment, then S_DONE; the walker
//   writes one bitmap cell per cycle through the single ram write port
// item ready comes back in the same cycle as the result register is loaded
// after reset the bitmap is swept clear, all MAX_COLS * MAX_ROWS cells (4096),
//   with item ready low; config writes are taken meanwhile
// one item at a time; a finished result sits in the output register, so the
//   next item is accepted before that result beat is taken
module polyline_grid_rasterizer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    pgr_in_if.sink                        item,
    pgr_out_if.source                     result,
    input  logic                          cfg_wen,
    input  logic [pgr_pkg::CFG_I_W-1:0]   cfg_index,
    input  logic [pgr_pkg::DIM_W-1:0]     cfg_data
);

    // sequencer states
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_WALK  = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // grid size registers
    logic [pgr_pkg::DIM_W-1:0] cols_reg, rows_reg;

    // clearing sweep address
    logic [pgr_pkg::ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // latched item
    pgr_pkg::func_t                func_reg, func_next;
    logic [pgr_pkg::CRD_IN_W-1:0]  x_reg, x_next;
    logic [pgr_pkg::CRD_IN_W-1:0]  y_reg, y_next;

    // drawing state
    logic [pgr_pkg::COL_W-1:0] cur_x_reg, cur_x_next;
    logic [pgr_pkg::ROW_W-1:0] cur_y_reg, cur_y_next;
    logic                      failed_reg, failed_next;
    logic [pgr_pkg::CNT_W-1:0] line_reg, line_next;
    logic [pgr_pkg::CNT_W-1:0] vtx_reg, vtx_next;
    logic [pgr_pkg::CNT_W-1:0] err_line_reg, err_line_next;
    logic [pgr_pkg::CNT_W-1:0] err_vtx_reg, err_vtx_next;

    // walker
    logic [pgr_pkg::COL_W-1:0] walk_x_reg, walk_x_next;
    logic [pgr_pkg::ROW_W-1:0] walk_y_reg, walk_y_next;
    logic [pgr_pkg::CRD_W-1:0] walk_cnt_reg, walk_cnt_next;
    pgr_pkg::step_t            step_reg, step_next;

    // pending result
    pgr_pkg::status_t res_status_reg, res_status_next;
    logic             res_cell_reg, res_cell_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    pgr_pkg::status_t          out_status_reg, out_status_next;
    logic [pgr_pkg::CNT_W-1:0] out_line_reg, out_line_next;
    logic [pgr_pkg::CNT_W-1:0] out_vtx_reg, out_vtx_next;
    logic                      out_cell_reg, out_cell_next;

    // bitmap ram
    logic                       ram_we;
    logic [pgr_pkg::ADDR_W-1:0] ram_waddr;
    logic [pgr_pkg::ADDR_W-1:0] ram_raddr;
    logic                       ram_rdata;

    // checks on the latched item
    logic [pgr_pkg::CRD_IN_W-1:0] eff_cols, eff_rows;
    logic                         in_grid;
    logic [pgr_pkg::COL_W-1:0]    x_low;
    logic [pgr_pkg::ROW_W-1:0]    y_low;
    logic signed [pgr_pkg::CRD_W:0] dx, dy;
    logic [pgr_pkg::CRD_W:0]      adx, ady, seg_len;
    logic                         bad_dir;

    assign eff_cols = pgr_pkg::eff_dim(cols_reg, pgr_pkg::MAX_COLS);
    assign eff_rows = pgr_pkg::eff_dim(rows_reg, pgr_pkg::MAX_ROWS);
    assign in_grid  = !x_reg[pgr_pkg::CRD_IN_W-1] && !y_reg[pgr_pkg::CRD_IN_W-1] &&
                      (x_reg < eff_cols) && (y_reg < eff_rows);

    // low bits are the full coordinate whenever the point is in the grid
    assign x_low = x_reg[pgr_pkg::COL_W-1:0];
    assign y_low = y_reg[pgr_pkg::ROW_W-1:0];

    // deltas from the cursor, one sign bit wider than any coordinate
    assign dx  = $signed({1'b0, pgr_pkg::CRD_W'(x_low)}) -
                 $signed({1'b0, pgr_pkg::CRD_W'(cur_x_reg)});
    assign dy  = $signed({1'b0, pgr_pkg::CRD_W'(y_low)}) -
                 $signed({1'b0, pgr_pkg::CRD_W'(cur_y_reg)});
    assign adx = dx[pgr_pkg::CRD_W] ? (pgr_pkg::CRD_W+1)'(-dx) : (pgr_pkg::CRD_W+1)'(dx);
    assign ady = dy[pgr_pkg::CRD_W] ? (pgr_pkg::CRD_W+1)'(-dy) : (pgr_pkg::CRD_W+1)'(dy);
    assign bad_dir = (dx != '0) && (dy != '0) && (adx != ady);
    assign seg_len = (adx > ady) ? adx : ady;

    assign ram_raddr = pgr_pkg::cell_addr(y_low, x_low);

    // handshakes
    assign item.ready        = (state_reg == S_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.status     = out_status_reg;
    assign result.err_line   = out_line_reg;
    assign result.err_vertex = out_vtx_reg;
    assign result.cell_res   = out_cell_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        func_next       = func_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        failed_next     = failed_reg;
        line_next       = line_reg;
        vtx_next        = vtx_reg;
        err_line_next   = err_line_reg;
        err_vtx_next    = err_vtx_reg;
        walk_x_next     = walk_x_reg;
        walk_y_next     = walk_y_reg;
        walk_cnt_next   = walk_cnt_reg;
        step_next       = step_reg;
        res_status_next = res_status_reg;
        res_cell_next   = res_cell_reg;
        out_status_next = out_status_reg;
        out_line_next   = out_line_reg;
        out_vtx_next    = out_vtx_reg;
        out_cell_next   = out_cell_reg;
        ram_we          = 1'b0;
        ram_waddr       = pgr_pkg::cell_addr(walk_y_reg, walk_x_reg);

        // result beat taken
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                if (clr_addr_reg == pgr_pkg::ADDR_W'(pgr_pkg::DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (item.valid)
                begin
                    func_next  = pgr_pkg::func_t'(item.func);
                    x_next     = item.x;
                    y_next     = item.y;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                res_status_next = pgr_pkg::ST_OK;
                res_cell_next   = 1'b0;
                state_next      = S_DONE;
                case (func_reg)
                    pgr_pkg::FN_START:
                    begin
                        line_next = line_reg + 1'b1;
                        vtx_next  = pgr_pkg::CNT_W'(1);
                        if (failed_reg)
                        begin
                            res_status_next = pgr_pkg::ST_IGNORED;
                        end
                        else if (!in_grid)
                        begin
                            // start point off the grid counts as vertex 1
                            failed_next     = 1'b1;
                            err_line_next   = line_reg + 1'b1;
                            err_vtx_next    = pgr_pkg::CNT_W'(1);
                            res_status_next = pgr_pkg::ST_RAISED;
                        end
                        else
                        begin
                            cur_x_next = x_low;
                            cur_y_next = y_low;
                        end
                    end

                    pgr_pkg::FN_VERTEX:
                    begin
                        vtx_next = vtx_reg + 1'b1;
                        if (failed_reg)
                        begin
                            res_status_next = pgr_pkg::ST_IGNORED;
                        end
                        else if (!in_grid || bad_dir)
                        begin
                            failed_next     = 1'b1;
                            err_line_next   = line_reg;
                            err_vtx_next    = vtx_reg + 1'b1;
                            res_status_next = pgr_pkg::ST_RAISED;
                        end
                        else
                        begin
                            // walk from the cursor, the cursor jumps to the vertex now
                            walk_x_next    = cur_x_reg;
                            walk_y_next    = cur_y_reg;
                            walk_cnt_next  = seg_len[pgr_pkg::CRD_W-1:0];
                            step_next.xinc = (dx > 0);
                            step_next.xdec = (dx < 0);
                            step_next.yinc = (dy > 0);
                            step_next.ydec = (dy < 0);
                            cur_x_next     = x_low;
                            cur_y_next     = y_low;
                            state_next     = S_WALK;
                        end
                    end

                    pgr_pkg::FN_READ:
                    begin
                        if (failed_reg || !in_grid)
                        begin
                            res_status_next = pgr_pkg::ST_REFUSED;
                        end
                        else
                        begin
                            // ram read issued this cycle from the latched point
                            state_next = S_READ;
                        end
                    end

                    default:
                    begin
                        res_status_next = pgr_pkg::ST_OK;
                    end
                endcase
            end

            S_WALK:
            begin
                ram_we = 1'b1;
                if (walk_cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    walk_cnt_next = walk_cnt_reg - 1'b1;
                    if (step_reg.xinc)
                    begin
                        walk_x_next = walk_x_reg + 1'b1;
                    end
                    else if (step_reg.xdec)
                    begin
                        walk_x_next = walk_x_reg - 1'b1;
                    end
                    if (step_reg.yinc)
                    begin
                        walk_y_next = walk_y_reg + 1'b1;
                    end
                    else if (step_reg.ydec)
                    begin
                        walk_y_next = walk_y_reg - 1'b1;
                    end
                end
            end

            S_READ:
            begin
                res_cell_next = ram_rdata;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                // wait for a free output register
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_line_next   = failed_reg ? err_line_reg : '0;
                    out_vtx_next    = failed_reg ? err_vtx_reg : '0;
                    out_cell_next   = res_cell_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            cols_reg      <= pgr_pkg::DIM_W'(64);
            rows_reg      <= pgr_pkg::DIM_W'(64);
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            failed_reg    <= 1'b0;
            line_reg      <= '0;
            vtx_reg       <= '0;
            err_line_reg  <= '0;
            err_vtx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            failed_reg    <= failed_next;
            line_reg      <= line_next;
            vtx_reg       <= vtx_next;
            err_line_reg  <= err_line_next;
            err_vtx_reg   <= err_vtx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (pgr_pkg::cfg_idx_t'(cfg_index))
                    pgr_pkg::CFG_COLS: cols_reg <= cfg_data;
                    pgr_pkg::CFG_ROWS: rows_reg <= cfg_data;
                    default:           cols_reg <= cols_reg;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        walk_x_reg     <= walk_x_next;
        walk_y_reg     <= walk_y_next;
        walk_cnt_reg   <= walk_cnt_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_cell_reg   <= res_cell_next;
        out_status_reg <= out_status_next;
        out_line_reg   <= out_line_next;
        out_vtx_reg    <= out_vtx_next;
        out_cell_reg   <= out_cell_next;
    end

    pgr_ram #(
        .WIDTH (1),
        .DEPTH (pgr_pkg::DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (state_reg != S_CLEAR),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // bitmap is written only by the clearing sweep or the walker
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WALK))
        else $error("bitmap written outside sweep or walk");

    // a raised error result is only seen with the sticky flag set
    a_raised_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == pgr_pkg::ST_RAISED) |->
            (failed_reg && out_vtx_reg != '0 || failed_reg && out_line_reg != '0 ||
             failed_reg))
        else $error("error result without failure flag");

    // a set cell only comes back on a plain successful beat
    a_cell_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cell_reg) |-> (out_status_reg == pgr_pkg::ST_OK))
        else $error("cell value on a non-ok result");

    // the failure flag never drops once set
    a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |=> failed_reg)
        else $error("failure flag cleared");
`endif

endmodule

// ----- tb/sv/pgr_raster_checker.sv -----
// checker of the polyline grid rasterizer: predicts each result and compares it with the block
module pgr_raster_checker
    import pgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pgr_in_if                  item,
    pgr_out_if                 result,
    input  logic               cfg_wen,
    input  logic [CFG_I_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]   cfg_data,
    output int                 mismatches,
    output int                 pending,
    output int                 cols_live,
    output int                 rows_live
);

    typedef struct packed {
        status_t     status;
        logic [15:0] line;
        logic [15:0] vertex;
        logic        cell_bit;
    } outcome_t;

    // shadow of the block state
    logic [DIM_W-1:0] grid_cols;
    logic [DIM_W-1:0] grid_rows;
    logic             cells [DEPTH];
    int               cur_x;
    int               cur_y;
    logic             failed;
    logic [15:0]      line_count;
    logic [15:0]      vertex_count;
    logic [15:0]      first_line;
    logic [15:0]      first_vertex;

    outcome_t         pending_results [$];
    int               reported;

    function automatic int dim_in_use(logic [DIM_W-1:0] v, int maxv);
        if (v == '0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    assign cols_live = dim_in_use(grid_cols, MAX_COLS);
    assign rows_live = dim_in_use(grid_rows, MAX_ROWS);

    function automatic bit on_grid(int px, int py);
        return px >= 0 && py >= 0 && px < dim_in_use(grid_cols, MAX_COLS)
            && py < dim_in_use(grid_rows, MAX_ROWS);
    endfunction

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic int dir_of(int v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic void mark_cell(int px, int py);
        if (px < 0 || py < 0 || px >= MAX_COLS || py >= MAX_ROWS)
            cells[0] = 1'b1;
        else
            cells[py * MAX_COLS + px] = 1'b1;
    endfunction

    function automatic void record_failure();
        failed       = 1'b1;
        first_line   = line_count;
        first_vertex = vertex_count;
    endfunction

    // applies one item to the shadow state and returns the result it causes
    function automatic outcome_t rasterize(func_t f, logic [15:0] xin, logic [15:0] yin);
        outcome_t o;
        int       px;
        int       py;
        int       dx;
        int       dy;
        int       sx;
        int       sy;
        int       n;
        px = int'($signed(xin));
        py = int'($signed(yin));
        o  = '{ST_OK, 16'd0, 16'd0, 1'b0};
        case (f)
            FN_START:
            begin
                line_count   = line_count + 16'd1;
                vertex_count = 16'd1;
                if (failed)
                    o.status = ST_IGNORED;
                else if (!on_grid(px, py))
                begin
                    record_failure();
                    o.status = ST_RAISED;
                end
                else
                begin
                    cur_x = px;
                    cur_y = py;
                end
            end
            FN_VERTEX:
            begin
                vertex_count = vertex_count + 16'd1;
                if (failed)
                    o.status = ST_IGNORED;
                else
                begin
                    dx = px - cur_x;
                    dy = py - cur_y;
                    if (!on_grid(px, py) || (dx != 0 && dy != 0 && mag(dx) != mag(dy)))
                    begin
                        record_failure();
                        o.status = ST_RAISED;
                    end
                    else
                    begin
                        sx = dir_of(dx);
                        sy = dir_of(dy);
                        n  = (mag(dx) > mag(dy)) ? mag(dx) : mag(dy);
                        for (int k = 0; k <= n; k++)
                            mark_cell(cur_x + k * sx, cur_y + k * sy);
                        cur_x = px;
                        cur_y = py;
                    end
                end
            end
            FN_READ:
            begin
                if (failed || !on_grid(px, py))
                    o.status = ST_REFUSED;
                else
                    o.cell_bit = cells[py * MAX_COLS + px];
            end
            default:
            begin
            end
        endcase
        if (failed)
        begin
            o.line   = first_line;
            o.vertex = first_vertex;
        end
        return o;
    endfunction

    task automatic flag_field(string name, int want, int got);
        mismatches++;
        if (reported < 60)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        reported++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            grid_cols    = DIM_W'(64);
            grid_rows    = DIM_W'(64);
            foreach (cells[i])
                cells[i] = 1'b0;
            cur_x        = 0;
            cur_y        = 0;
            failed       = 1'b0;
            line_count   = '0;
            vertex_count = '0;
            first_line   = '0;
            first_vertex = '0;
            pending_results.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_COLS: grid_cols = cfg_data;
                    CFG_ROWS: grid_rows = cfg_data;
                    default:  ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (reported < 60)
                        $display("%0t: result beat with nothing expected, status %0d",
                                 $time, result.status);
                    reported++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.status !== want.status)
                        flag_field("status", int'(want.status), int'(result.status));
                    if (result.err_line !== want.line)
                        flag_field("err_line", int'(want.line), int'(result.err_line));
                    if (result.err_vertex !== want.vertex)
                        flag_field("err_vertex", int'(want.vertex), int'(result.err_vertex));
                    if (result.cell_res !== want.cell_bit)
                        flag_field("cell_res", int'(want.cell_bit), int'(result.cell_res));
                end
            end
            if (item.valid && item.ready)
                pending_results.push_back(rasterize(func_t'(item.func), item.x, item.y));
            pending = pending_results.size();
        end
    end

    initial
    begin
        mismatches = 0;
        reported   = 0;
    end

endmodule

// ----- tb/sv/polyline_grid_rasterizer_unit_tb.sv -----
// testbench top of the polyline grid rasterizer: stimulus, idling and verdict
module polyline_grid_rasterizer_unit_tb;
    import pgr_pkg::*;

    // worst case is far below this: ~1000 items, each walking at most 64 cells, plus stalls
    localparam int CYCLE_LIMIT = 600000;

    logic               clk;
    logic               rst_n;
    logic               cfg_wen;
    logic [CFG_I_W-1:0] cfg_index;
    logic [DIM_W-1:0]   cfg_data;

    int fail_count;
    int pending_cnt;
    int cols_live;
    int rows_live;

    // generator view of the cursor, kept in step with every drawing beat we send
    int gen_cx;
    int gen_cy;
    // sender burst bookkeeping
    int burst_left;
    // receiver stall pattern
    int ready_mode;
    int mode_left;

    pgr_in_if  item_ch ();
    pgr_out_if result_ch ();

    polyline_grid_rasterizer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pgr_raster_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (fail_count),
        .pending    (pending_cnt),
        .cols_live  (cols_live),
        .rows_live  (rows_live)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // every input known from time zero
    initial
    begin
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = CFG_COLS;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.func    = FN_NONE;
        item_ch.x       = '0;
        item_ch.y       = '0;
        result_ch.ready = 1'b0;
        gen_cx          = 0;
        gen_cy          = 0;
        burst_left      = 0;
        ready_mode      = 0;
        mode_left       = 0;
    end

    // receiver: stall pattern switches between always ready, coin flip, sparse and very sparse
    always @(negedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 160);
        end
        else
            mode_left--;
        case (ready_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= 1'($urandom_range(0, 1));
            2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
            default: result_ch.ready <= ($urandom_range(0, 11) == 0);
        endcase
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** polyline_grid_rasterizer_unit: FAILED **");
        $finish;
    end

    // one item beat; valid stays high afterwards so a burst runs back to back
    task automatic feed_item(func_t f, int px, int py);
        int gap;
        if (burst_left == 0)
        begin
            // long bursts now and then give stretches with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.func  <= f;
        item_ch.x     <= px[15:0];
        item_ch.y     <= py[15:0];
        do
            @(posedge clk);
        while (!item_ch.ready);
        burst_left--;
    endtask

    // sender goes quiet until every expected beat has come back, then a short hold-off
    task automatic wait_quiet(int extra);
        @(negedge clk);
        item_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (pending_cnt != 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic set_grid(int cols, int rows);
        @(negedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_COLS;
        cfg_data  <= cols[DIM_W-1:0];
        @(negedge clk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows[DIM_W-1:0];
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    function automatic bit fits(int px, int py);
        return px >= 0 && py >= 0 && px < cols_live && py < rows_live;
    endfunction

    task automatic begin_line(int px, int py);
        feed_item(FN_START, px, py);
        gen_cx = px;
        gen_cy = py;
    endtask

    task automatic draw_to(int px, int py);
        feed_item(FN_VERTEX, px, py);
        gen_cx = px;
        gen_cy = py;
    endtask

    task automatic begin_random_line();
        begin_line($urandom_range(0, cols_live - 1), $urandom_range(0, rows_live - 1));
    endtask

    // legal segment from the cursor in one of eight directions or of zero length, short ones preferred;
    // the cursor may lie outside a shrunken grid, so only reachable lengths qualify
    task automatic draw_random_segment();
        int  dir;
        int  sx;
        int  sy;
        int  lengths [$];
        int  k;
        bit  done;
        done = 1'b0;
        for (int tries = 0; tries < 16 && !done; tries++)
        begin
            dir = $urandom_range(0, 8);
            case (dir)
                0:       begin sx =  1; sy =  0; end
                1:       begin sx =  1; sy =  1; end
                2:       begin sx =  0; sy =  1; end
                3:       begin sx = -1; sy =  1; end
                4:       begin sx = -1; sy =  0; end
                5:       begin sx = -1; sy = -1; end
                6:       begin sx =  0; sy = -1; end
                7:       begin sx =  1; sy = -1; end
                default: begin sx =  0; sy =  0; end
            endcase
            lengths.delete();
            if (sx == 0 && sy == 0)
            begin
                // zero-length segment
                if (fits(gen_cx, gen_cy))
                    lengths.push_back(0);
            end
            else
            begin
                for (int n = 1; n <= MAX_COLS; n++)
                    if (fits(gen_cx + n * sx, gen_cy + n * sy))
                        lengths.push_back(n);
            end
            if (lengths.size() != 0)
            begin
                if ($urandom_range(0, 3) != 0)
                    k = lengths[$urandom_range(0, (lengths.size() < 4 ? lengths.size() : 4) - 1)];
                else
                    k = lengths[$urandom_range(0, lengths.size() - 1)];
                draw_to(gen_cx + k * sx, gen_cy + k * sy);
                done = 1'b1;
            end
        end
        if (!done)
            begin_random_line();
    endtask

    // reads: mostly in the grid, some near the cursor, some just off the edge, some wild
    task automatic probe_cell();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            feed_item(FN_READ, $urandom_range(0, cols_live - 1), $urandom_range(0, rows_live - 1));
        else if (roll < 75)
            feed_item(FN_READ, gen_cx + $urandom_range(0, 2) - 1, gen_cy + $urandom_range(0, 2) - 1);
        else if (roll < 85)
        begin
            case ($urandom_range(0, 3))
                0:       feed_item(FN_READ, cols_live, $urandom_range(0, rows_live - 1));
                1:       feed_item(FN_READ, $urandom_range(0, cols_live - 1), rows_live);
                2:       feed_item(FN_READ, -1, $urandom_range(0, rows_live - 1));
                default: feed_item(FN_READ, $urandom_range(0, cols_live - 1), -1);
            endcase
        end
        else
            feed_item(FN_READ, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // unused func code with random coordinates
    task automatic feed_noise();
        feed_item(FN_NONE, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    // well-formed drawing with reads, unused func codes and quiet spells mixed in; segments
    // may be drawn from a cursor left over from the previous grid
    task automatic random_phase(int count);
        int sent;
        int roll;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                draw_random_segment();
                sent++;
            end
            else if (roll < 63)
            begin
                begin_random_line();
                sent++;
            end
            else if (roll < 92)
            begin
                probe_cell();
                sent++;
            end
            else if (roll < 98)
                feed_noise();
            else
                wait_quiet(0);
        end
    endtask

    initial
    begin : stimulus
        int plan_cols [10];
        int plan_rows [10];
        plan_cols = '{1, 0, 127, 8, 64, 1, 100, 0, 17, 64};
        plan_rows = '{1, 0, 127, 5, 1, 64, 3, 0, 40, 64};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // registers are taken during the clearing sweep
        set_grid(64, 64);

        // directed: vertex before any start is drawn from (0,0) as polyline 0
        feed_item(FN_READ, 0, 0);
        draw_to(3, 0);
        feed_item(FN_READ, 3, 0);
        feed_item(FN_READ, 4, 0);
        // longest diagonal, then the grid edges and a zero-length segment
        begin_line(63, 63);
        draw_to(0, 0);
        feed_item(FN_READ, 31, 31);
        begin_line(0, 63);
        draw_to(0, 0);
        draw_to(63, 0);
        draw_to(63, 0);
        draw_to(63, 63);
        feed_item(FN_READ, 63, 40);
        feed_item(FN_READ, 62, 40);
        // unused func code
        feed_item(FN_NONE, -1, -1);
        // reads outside the grid are refused without setting the failure
        feed_item(FN_READ, 64, 0);
        feed_item(FN_READ, 0, 64);
        feed_item(FN_READ, -1, 5);
        feed_item(FN_READ, -32768, 32767);
        feed_item(FN_READ, 32767, -32768);
        begin_line(5, 5);
        draw_to(7, 3);
        feed_item(FN_READ, 6, 4);
        wait_quiet(8);

        // settings sweep: extremes, zero and oversize values, shrinking mid-polyline
        for (int p = 0; p < 10; p++)
        begin
            if (p == 7)
                set_grid($urandom_range(0, 127), $urandom_range(0, 127));
            else
                set_grid(plan_cols[p], plan_rows[p]);
            random_phase(95);
            wait_quiet(8);
        end

        // sticky failure last, one way of raising it per run
        set_grid(64, 64);
        if (!fits(gen_cx, gen_cy))
            begin_random_line();
        case ($urandom_range(0, 2))
            0:       feed_item(FN_START, ($urandom_range(0, 1) != 0) ? 64 : -3,
                               $urandom_range(0, 63));
            1:       feed_item(FN_VERTEX, ($urandom_range(0, 1) != 0) ? -1 : 32767, gen_cy);
            default: feed_item(FN_VERTEX, gen_cx + 1, gen_cy + 2);
        endcase
        // drawing after it is ignored and reads are refused, counters still advance
        feed_item(FN_START, 70, 70);
        feed_item(FN_START, 3, 3);
        feed_item(FN_VERTEX, 3, 9);
        feed_item(FN_VERTEX, 4, 4);
        feed_item(FN_READ, 3, 3);
        feed_item(FN_NONE, 0, 0);
        random_phase(40);

        wait_quiet(16);
        if (fail_count == 0 && pending_cnt == 0)
            $display("** polyline_grid_rasterizer_unit: PASSED **");
        else
            $display("** polyline_grid_rasterizer_unit: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pgr_pkg.sv
rtl/pgr_in_if.sv
rtl/pgr_out_if.sv
rtl/pgr_ram.sv
rtl/polyline_grid_rasterizer_unit.sv
tb/sv/pgr_raster_checker.sv
tb/sv/polyline_grid_rasterizer_unit_tb.sv
